>>> src/rnh_pkg.sv
package rnh_pkg;

   localparam int COORD_W    = 24;
   localparam int RANGE_W    = 23;
   localparam int DIFF_W     = 25;
   localparam int DIR_W      = 16;
   localparam int MUL_W      = 50;
   localparam int WIDE_W     = 58;
   localparam int ITER_W     = 66;
   localparam int CNT_W      = 5;
   localparam int SQRT_STEPS = 29;
   localparam int DIV_STEPS  = 24;
   localparam int DIR_BITS   = 14;
   localparam int SQRT_TOP   = 56;

   localparam int SINE_DEPTH = 256;
   localparam int IDX_BITS   = 8;
   localparam int QUARTER    = SINE_DEPTH / 4;
   localparam int ROM_IDX_W  = IDX_BITS - 1;

   localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 23'd81920;

   localparam logic [1:0] MODE_CIRCLE  = 2'd0;
   localparam logic [1:0] MODE_SEGMENT = 2'd1;

   typedef logic [14:0] sine_rom_type [0:QUARTER];

   // Taylor series to x^11 on the first quadrant in Q30, rounded to Q14
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type      rom;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   t;
      longint unsigned   s;
      longint unsigned   one;
      longint unsigned   half_pi;
      one     = 64'd1073741824;
      half_pi = 64'd1686629713;
      for (int r = 0; r <= QUARTER; r++) begin
         x  = (half_pi * 64'(r)) / QUARTER;
         x2 = (x * x) >> 30;
         t  = one - x2 / 110;
         t  = one - ((x2 * t) >> 30) / 72;
         t  = one - ((x2 * t) >> 30) / 42;
         t  = one - ((x2 * t) >> 30) / 20;
         t  = one - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         s  = (s + 64'd32768) >> 16;
         if (s > 64'd16384) begin
            s = 64'd16384;
         end
         rom[r] = s[14:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   function automatic logic signed [DIR_W-1:0] table_sine(input logic [IDX_BITS-1:0] idx);
      logic [ROM_IDX_W-1:0]    r;
      logic [ROM_IDX_W-1:0]    pos;
      logic signed [DIR_W-1:0] mag;
      r   = {1'b0, idx[IDX_BITS-3:0]};
      pos = idx[IDX_BITS-2] ? ROM_IDX_W'(QUARTER) - r : r;
      mag = $signed({1'b0, SINE_ROM[pos]});
      return idx[IDX_BITS-1] ? -mag : mag;
   endfunction

   typedef struct packed {
      logic capture;
      logic diff;
      logic mul;
      logic comb;
      logic square;
      logic prep;
      logic step;
      logic finish;
   } rnh_cmd_type;

   typedef struct packed {
      logic is_circle;
      logic is_segment;
      logic prep_miss;
      logic iter_last;
      logic out_free;
      logic last;
   } rnh_stat_type;

endpackage

>>> src/ray_nearest_hit_range.sv
// Ray nearest-hit range unit.
// Each request carries a ray (origin, bearing) and one obstacle primitive:
// a circle, a wall segment or none. A run of requests ending with last = 1
// forms one ray; the nearest hit over the run, clamped to max_range, comes
// out as one response on rsp_range with rsp_hit set when it is below max_range.
// Requests are taken when req_valid is high and req_stall low; responses leave
// when rsp_valid is high and rsp_stall low. csr_wr_en writes max_range.
// Each request passes through the steps capture, diff, mul, comb, square (circle
// only), prep, iterate and finish before the next request is taken. A request
// with no primitive goes from diff to finish, and a miss found at prep skips the
// iteration. The 29-step square root and the 24-step division share one
// bit-per-cycle unit. The response of a ray is registered at the edge that ends
// its last request, as the controller returns to idle for the next request.
// While a response waits under rsp_stall, the next request is still taken and
// processed; only a new ray-final result waits for the output register.
// Reset (synchronous) clears the controller and holds req_stall high, sets
// max_range to 20 m and starts a new ray with the next request.
module ray_nearest_hit_range (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [rnh_pkg::RANGE_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_mode,
   input  logic [rnh_pkg::COORD_W-1:0] req_origin_e,
   input  logic [rnh_pkg::COORD_W-1:0] req_origin_n,
   input  logic [15:0]                 req_bearing,
   input  logic [rnh_pkg::COORD_W-1:0] req_p0_e,
   input  logic [rnh_pkg::COORD_W-1:0] req_p0_n,
   input  logic [rnh_pkg::COORD_W-1:0] req_p1_e,
   input  logic [rnh_pkg::COORD_W-1:0] req_p1_n,
   input  logic [rnh_pkg::RANGE_W-1:0] req_radius,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rnh_pkg::RANGE_W-1:0] rsp_range,
   output logic                        rsp_hit
);
   import rnh_pkg::*;

   rnh_cmd_type  cmd;
   rnh_stat_type stat;

   // sequencer: one request at a time through the datapath steps
   rnh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // geometry, iterative root/divide unit, running minimum and output register
   rnh_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_mode     (req_mode),
      .req_origin_e (req_origin_e),
      .req_origin_n (req_origin_n),
      .req_bearing  (req_bearing),
      .req_p0_e     (req_p0_e),
      .req_p0_n     (req_p0_n),
      .req_p1_e     (req_p1_e),
      .req_p1_n     (req_p1_n),
      .req_radius   (req_radius),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_range    (rsp_range),
      .rsp_hit      (rsp_hit)
   );

endmodule

>>> src/rnh_iter.sv
module rnh_iter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       ld,
   input  logic                       ld_sqrt,
   input  logic [rnh_pkg::ITER_W-1:0] ld_rem,
   input  logic [rnh_pkg::ITER_W-1:0] ld_aux,
   input  logic                       step,
   output logic [rnh_pkg::ITER_W-1:0] res,
   output logic                       last_step
);
   import rnh_pkg::*;

   logic [ITER_W-1:0] rem_ff, rem_in;
   logic [ITER_W-1:0] aux_ff, aux_in;
   logic [ITER_W-1:0] res_ff, res_in;
   logic              sqrt_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ITER_W-1:0] trial;
   logic              ge;

   // one result bit per step: square root by bit pairs or restoring division
   always_comb begin
      trial  = sqrt_ff ? res_ff + aux_ff : aux_ff;
      ge     = rem_ff >= trial;
      rem_in = ge ? rem_ff - trial : rem_ff;
      if (sqrt_ff) begin
         res_in = ge ? (res_ff >> 1) + aux_ff : res_ff >> 1;
         aux_in = aux_ff >> 2;
      end else begin
         res_in = {res_ff[ITER_W-2:0], ge};
         aux_in = aux_ff >> 1;
      end
      cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         rem_ff  <= ld_rem;
         aux_ff  <= ld_aux;
         res_ff  <= '0;
         sqrt_ff <= ld_sqrt;
      end else if (step) begin
         rem_ff <= rem_in;
         aux_ff <= aux_in;
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ld) begin
         cnt_ff <= ld_sqrt ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
      end else if (step) begin
         cnt_ff <= cnt_in;
      end
   end

   assign res       = res_ff;
   assign last_step = cnt_ff == CNT_W'(1);

endmodule

>>> src/rnh_dpath.sv
module rnh_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  rnh_pkg::rnh_cmd_type        cmd,
   output rnh_pkg::rnh_stat_type       stat,
   input  logic                        csr_wr_en,
   input  logic [rnh_pkg::RANGE_W-1:0] csr_wr_data,
   input  logic [1:0]                  req_mode,
   input  logic [rnh_pkg::COORD_W-1:0] req_origin_e,
   input  logic [rnh_pkg::COORD_W-1:0] req_origin_n,
   input  logic [15:0]                 req_bearing,
   input  logic [rnh_pkg::COORD_W-1:0] req_p0_e,
   input  logic [rnh_pkg::COORD_W-1:0] req_p0_n,
   input  logic [rnh_pkg::COORD_W-1:0] req_p1_e,
   input  logic [rnh_pkg::COORD_W-1:0] req_p1_n,
   input  logic [rnh_pkg::RANGE_W-1:0] req_radius,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rnh_pkg::RANGE_W-1:0] rsp_range,
   output logic                        rsp_hit
);
   import rnh_pkg::*;

   logic [1:0]                mode_ff;
   logic                      last_ff;
   logic                      miss_ff;
   logic signed [COORD_W-1:0] oe_ff, on_ff, e0_ff, n0_ff, e1_ff, n1_ff;
   logic [15:0]               bearing_ff;
   logic [RANGE_W-1:0]        radius_ff;
   logic signed [DIR_W-1:0]   de_ff, dn_ff;
   logic signed [DIFF_W-1:0]  ae_ff, an_ff, se_ff, sn_ff;
   logic signed [MUL_W-1:0]   prod_ff [0:5];
   logic signed [WIDE_W-1:0]  x0_ff, x1_ff, x2_ff;
   logic [RANGE_W-1:0]        max_range_ff;
   logic [RANGE_W-1:0]        best_ff, best_in;
   logic                      ray_start_ff;
   logic                      rsp_valid_ff;
   logic [RANGE_W-1:0]        rsp_range_ff, rsp_range_in;
   logic                      rsp_hit_ff;

   logic                      is_circle, is_segment;
   logic [15:0]               idx_sum;
   logic [IDX_BITS-1:0]       idx_e, idx_n;
   logic signed [DIFF_W-1:0]  mul_a [0:5];
   logic signed [DIFF_W-1:0]  mul_b [0:5];
   logic signed [DIFF_W-1:0]  de_x, dn_x, r_x;
   logic signed [WIDE_W-1:0]  dot, b_full, cc, den_s, tn_s, un_s;
   logic signed [29:0]        b_s;
   logic signed [59:0]        bb;
   logic signed [WIDE_W-1:0]  disc, den, tn, un;
   logic                      neg, miss;
   logic [ITER_W-1:0]         ld_rem, ld_aux, res;
   logic                      iter_last;
   logic signed [31:0]        t1, t2;
   logic [RANGE_W-1:0]        cand, base;
   logic [23:0]               quo;

   assign is_circle  = mode_ff == MODE_CIRCLE;
   assign is_segment = mode_ff == MODE_SEGMENT;

   // bearing to table index, rounded to nearest step
   assign idx_sum = bearing_ff + 16'(1 << (16 - IDX_BITS - 1));
   assign idx_e   = idx_sum[15:16-IDX_BITS];
   assign idx_n   = idx_e + IDX_BITS'(QUARTER);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_mode;
         last_ff    <= req_last;
         miss_ff    <= req_mode[1];
         oe_ff      <= $signed(req_origin_e);
         on_ff      <= $signed(req_origin_n);
         e0_ff      <= $signed(req_p0_e);
         n0_ff      <= $signed(req_p0_n);
         e1_ff      <= $signed(req_p1_e);
         n1_ff      <= $signed(req_p1_n);
         bearing_ff <= req_bearing;
         radius_ff  <= req_radius;
      end else if (cmd.prep) begin
         miss_ff <= miss;
      end
   end

   // direction and coordinate differences
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         de_ff <= table_sine(idx_e);
         dn_ff <= table_sine(idx_n);
         if (is_segment) begin
            ae_ff <= DIFF_W'(e0_ff) - DIFF_W'(oe_ff);
            an_ff <= DIFF_W'(n0_ff) - DIFF_W'(on_ff);
         end else begin
            ae_ff <= DIFF_W'(oe_ff) - DIFF_W'(e0_ff);
            an_ff <= DIFF_W'(on_ff) - DIFF_W'(n0_ff);
         end
         se_ff <= DIFF_W'(e1_ff) - DIFF_W'(e0_ff);
         sn_ff <= DIFF_W'(n1_ff) - DIFF_W'(n0_ff);
      end
   end

   // six products in parallel, operands picked by primitive kind
   always_comb begin
      de_x = DIFF_W'(de_ff);
      dn_x = DIFF_W'(dn_ff);
      r_x  = $signed({2'b00, radius_ff});
      if (is_segment) begin
         mul_a[0] = de_x;  mul_b[0] = sn_ff;
         mul_a[1] = dn_x;  mul_b[1] = se_ff;
         mul_a[2] = ae_ff; mul_b[2] = sn_ff;
         mul_a[3] = an_ff; mul_b[3] = se_ff;
         mul_a[4] = ae_ff; mul_b[4] = dn_x;
         mul_a[5] = an_ff; mul_b[5] = de_x;
      end else begin
         mul_a[0] = ae_ff; mul_b[0] = de_x;
         mul_a[1] = an_ff; mul_b[1] = dn_x;
         mul_a[2] = ae_ff; mul_b[2] = ae_ff;
         mul_a[3] = an_ff; mul_b[3] = an_ff;
         mul_a[4] = r_x;   mul_b[4] = r_x;
         mul_a[5] = '0;    mul_b[5] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= mul_a[i] * mul_b[i];
         end
      end
   end

   // circle: b and c of the quadratic; segment: den, tn, un
   always_comb begin
      dot    = WIDE_W'(prod_ff[0]) + WIDE_W'(prod_ff[1]);
      b_full = (dot + WIDE_W'(1 << (DIR_BITS - 1))) >>> DIR_BITS;
      cc     = WIDE_W'(prod_ff[2]) + WIDE_W'(prod_ff[3]) - WIDE_W'(prod_ff[4]);
      den_s  = WIDE_W'(prod_ff[0]) - WIDE_W'(prod_ff[1]);
      tn_s   = WIDE_W'(prod_ff[2]) - WIDE_W'(prod_ff[3]);
      un_s   = WIDE_W'(prod_ff[4]) - WIDE_W'(prod_ff[5]);
      b_s    = $signed(x0_ff[29:0]);
      bb     = b_s * b_s;
   end

   always_ff @(posedge clock) begin
      if (cmd.comb) begin
         if (is_segment) begin
            x0_ff <= den_s;
            x1_ff <= tn_s;
            x2_ff <= un_s;
         end else begin
            x0_ff <= b_full;
            x1_ff <= cc;
         end
      end else if (cmd.square) begin
         x2_ff <= $signed(bb[WIDE_W-1:0]);
      end
   end

   // miss tests and operand load for the iterative unit
   always_comb begin
      disc   = x2_ff - x1_ff;
      neg    = x0_ff < 0;
      den    = neg ? -x0_ff : x0_ff;
      tn     = neg ? -x1_ff : x1_ff;
      un     = neg ? -x2_ff : x2_ff;
      ld_rem = '0;
      ld_aux = '0;
      if (is_segment) begin
         miss   = (x0_ff == 0) || (tn < 0) || (un < 0) || (un > den)
                  || (tn >= (den <<< 10));
         ld_rem = ITER_W'(tn) << DIR_BITS;
         ld_aux = ITER_W'(den) << (DIV_STEPS - 1);
      end else begin
         miss   = disc < 0;
         ld_rem = ITER_W'(disc);
         ld_aux = ITER_W'(1) << SQRT_TOP;
      end
   end

   rnh_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .ld        (cmd.prep),
      .ld_sqrt   (!is_segment),
      .ld_rem    (ld_rem),
      .ld_aux    (ld_aux),
      .step      (cmd.step),
      .res       (res),
      .last_step (iter_last)
   );

   // candidate range and running minimum
   always_comb begin
      t1   = -32'(b_s) - $signed({3'b000, res[SQRT_STEPS-1:0]});
      t2   = -32'(b_s) + $signed({3'b000, res[SQRT_STEPS-1:0]});
      quo  = res[DIV_STEPS-1:0];
      cand = max_range_ff;
      if (!miss_ff) begin
         if (is_circle) begin
            if (t2 < 0) begin
               cand = max_range_ff;
            end else if (t1 < 0) begin
               cand = '0;
            end else if (t1 > $signed({9'd0, max_range_ff})) begin
               cand = max_range_ff;
            end else begin
               cand = t1[RANGE_W-1:0];
            end
         end else if (is_segment) begin
            cand = (quo > {1'b0, max_range_ff}) ? max_range_ff : quo[RANGE_W-1:0];
         end
      end
      base         = ray_start_ff ? max_range_ff : best_ff;
      best_in      = (cand < base) ? cand : base;
      rsp_range_in = (best_in < max_range_ff) ? best_in : max_range_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RESET;
         best_ff      <= MAX_RANGE_RESET;
         ray_start_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_range_ff <= csr_wr_data;
         end
         if (cmd.finish) begin
            best_ff      <= best_in;
            ray_start_ff <= last_ff;
         end
         if (cmd.finish && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && last_ff) begin
         rsp_range_ff <= rsp_range_in;
         rsp_hit_ff   <= rsp_range_in < max_range_ff;
      end
   end

   assign stat.is_circle  = is_circle;
   assign stat.is_segment = is_segment;
   assign stat.prep_miss  = miss;
   assign stat.iter_last  = iter_last;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.last       = last_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_range = rsp_range_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

>>> src/rnh_ctrl.sv
module rnh_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rnh_pkg::rnh_stat_type stat,
   output rnh_pkg::rnh_cmd_type  cmd
);
   import rnh_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIFF = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_COMB = 3'd3;
   localparam logic [2:0] S_SQR  = 3'd4;
   localparam logic [2:0] S_PREP = 3'd5;
   localparam logic [2:0] S_ITER = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = (stat.is_circle || stat.is_segment) ? S_MUL : S_FIN;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = stat.is_segment ? S_PREP : S_SQR;
         end
         S_SQR: begin
            cmd.square = 1'b1;
            state_in   = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = stat.prep_miss ? S_FIN : S_ITER;
         end
         S_ITER: begin
            cmd.step = 1'b1;
            if (stat.iter_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the output register can take the ray's result
            if (!stat.last || stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);

endmodule
